// ----- design/pdce_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the polyline delta character encoder.
// No dependencies; imported by every module of the block.
package pdce_pkg;

    localparam int LAT_W   = 25;            // latitude input width
    localparam int LNG_W   = 26;            // longitude input width
    localparam int ZLAT_W  = LAT_W + 1;     // folded latitude delta width
    localparam int ZLNG_W  = LNG_W + 1;     // folded longitude delta width
    localparam int GRP_W   = 5;             // bits per output character group
    localparam int CNT_W   = 3;             // group count, 1..6
    localparam int CHAR_W  = 7;             // ASCII code width

    localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd63;
    localparam logic [CNT_W-1:0]  CNT_ONE   = 3'd1;

    // One kept point, ready for serialization.
    typedef struct packed {
        logic [ZLAT_W-1:0] z_lat;
        logic [CNT_W-1:0]  n_lat;
        logic [ZLNG_W-1:0] z_lng;
        logic [CNT_W-1:0]  n_lng;
    } t_entry;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LAT,
        PH_LNG
    } t_phase;

    // Number of 5-bit groups needed for a folded value (at least one).
    function automatic logic [CNT_W-1:0] group_count(input logic [ZLNG_W-1:0] z);
        logic [CNT_W-1:0] n;
        begin
            priority if (z[26:25] != 2'd0) n = 3'd6;
            else if (z[24:20] != 5'd0)      n = 3'd5;
            else if (z[19:15] != 5'd0)      n = 3'd4;
            else if (z[14:10] != 5'd0)      n = 3'd3;
            else if (z[9:5] != 5'd0)        n = 3'd2;
            else                            n = 3'd1;
            return n;
        end
    endfunction

endpackage

// ----- design/pdce_front.sv -----
`timescale 1ns / 1ps
// Front end: takes points, applies start/keep rules, forms folded deltas.
// Depends on pdce_pkg.
module pdce_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [pdce_pkg::LAT_W-1:0]   i_lat,
    input  logic [pdce_pkg::LNG_W-1:0]   i_lng,
    input  logic                         i_start,
    input  logic                         i_keep,
    output logic                         o_push,
    output pdce_pkg::t_entry             o_entry
);
    import pdce_pkg::*;

    logic [LAT_W-1:0]  r_prev_lat, n_prev_lat;
    logic [LNG_W-1:0]  r_prev_lng, n_prev_lng;
    logic [LAT_W-1:0]  base_lat;
    logic [LNG_W-1:0]  base_lng;
    logic [ZLAT_W-1:0] d_lat, z_lat;
    logic [ZLNG_W-1:0] d_lng, z_lng;
    logic              kept;

    // start of line measures from zero and always keeps the point
    assign kept     = i_start | i_keep;
    assign base_lat = i_start ? '0 : r_prev_lat;
    assign base_lng = i_start ? '0 : r_prev_lng;

    // exact deltas, one bit wider than the coordinates
    assign d_lat = {i_lat[LAT_W-1], i_lat} - {base_lat[LAT_W-1], base_lat};
    assign d_lng = {i_lng[LNG_W-1], i_lng} - {base_lng[LNG_W-1], base_lng};

    // sign fold: 2d, or ~(2d) when negative
    assign z_lat = {d_lat[ZLAT_W-2:0], 1'b0} ^ {ZLAT_W{d_lat[ZLAT_W-1]}};
    assign z_lng = {d_lng[ZLNG_W-2:0], 1'b0} ^ {ZLNG_W{d_lng[ZLNG_W-1]}};

    assign o_push        = i_accept & kept;
    assign o_entry.z_lat = z_lat;
    assign o_entry.n_lat = group_count({1'b0, z_lat});
    assign o_entry.z_lng = z_lng;
    assign o_entry.n_lng = group_count(z_lng);

    always_comb begin
        n_prev_lat = r_prev_lat;
        n_prev_lng = r_prev_lng;
        if (o_push) begin
            n_prev_lat = i_lat;
            n_prev_lng = i_lng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lat <= '0;
            r_prev_lng <= '0;
        end else begin
            r_prev_lat <= n_prev_lat;
            r_prev_lng <= n_prev_lng;
        end
    end

endmodule

// ----- design/pdce_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of encoded-point entries between front and back end.
// Depends on pdce_pkg.
module pdce_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pdce_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output pdce_pkg::t_entry o_entry
);
    import pdce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W2 = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W2-1:0] FULL_CNT = CNT_W2'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W2-1:0]  r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- design/pdce_back.sv -----
`timescale 1ns / 1ps
// Back end: serializes each entry into characters, one per cycle while the output is ready, into an
// output register. Depends on pdce_pkg.
module pdce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pdce_pkg::t_entry              i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pdce_pkg::CHAR_W-1:0]   o_char,
    output logic                          o_last
);
    import pdce_pkg::*;

    t_phase             r_phase, n_phase;
    logic [ZLAT_W-1:0]  r_z_lat, n_z_lat;
    logic [ZLNG_W-1:0]  r_z_lng, n_z_lng;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_n_lng, n_n_lng;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    logic               slot_free, busy, emit, grp_end, finish;
    logic [GRP_W-1:0]   grp;
    logic [CHAR_W-1:0]  ch;

    assign slot_free = !r_out_valid || i_ready;
    assign busy      = (r_phase != PH_IDLE);
    assign emit      = busy && slot_free;
    assign grp_end   = (r_cnt == CNT_ONE);
    assign finish    = emit && grp_end && (r_phase == PH_LNG);
    assign o_q_pop   = i_q_valid && (!busy || finish);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (o_q_pop) n_phase = PH_LAT;
            PH_LAT:  if (emit && grp_end) n_phase = PH_LNG;
            PH_LNG: begin
                if (finish) n_phase = o_q_pop ? PH_LAT : PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // current character: low group of the active value, continuation unless last
    always_comb begin
        grp = (r_phase == PH_LNG) ? r_z_lng[GRP_W-1:0] : r_z_lat[GRP_W-1:0];
        ch  = {1'b0, !grp_end, grp} + CHAR_BIAS;
    end

    // datapath and output register
    always_comb begin
        n_z_lat     = r_z_lat;
        n_z_lng     = r_z_lng;
        n_cnt       = r_cnt;
        n_n_lng     = r_n_lng;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (o_q_pop) begin
            n_z_lat = i_q_entry.z_lat;
            n_z_lng = i_q_entry.z_lng;
            n_cnt   = i_q_entry.n_lat;
            n_n_lng = i_q_entry.n_lng;
        end else if (emit) begin
            if (r_phase == PH_LAT) begin
                n_z_lat = r_z_lat >> GRP_W;
                n_cnt   = grp_end ? r_n_lng : r_cnt - 1'b1;
            end else begin
                n_z_lng = r_z_lng >> GRP_W;
                n_cnt   = r_cnt - 1'b1;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = ch;
            n_last      = finish;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z_lat <= n_z_lat;
        r_z_lng <= n_z_lng;
        r_cnt   <= n_cnt;
        r_n_lng <= n_n_lng;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// ----- design/polyline_delta_char_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the polyline delta character encoder: front end, entry queue,
// character serializer. Depends on pdce_pkg, pdce_front, pdce_fifo, pdce_back.
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------------
//  s       | in  | tdata: lat_e5, lng_e5; tuser: start_of_line, keep_point
//  m       | out | tdata: code_char; tlast: last_char (final char of a point)
//
// A kept point costs n_lat + n_lng characters (2..12), one per cycle while the
// output is ready, from the single back-end serializer; a dropped point costs its
// input beat and nothing downstream. The input stays ready while the queue
// (QUEUE_DEPTH entries) has room, so points keep flowing while the output stalls.
// Reset (i_rst_n low, synchronous) clears the previous point, queue and output.
module polyline_delta_char_encoder #(
    parameter int QUEUE_DEPTH = 2   // entries between front and back end, >= 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input points
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // [24:0] lat_e5, [50:25] lng_e5, [55:51] zero
    input  logic [1:0]  i_s_tuser,  // [0] start_of_line, [1] keep_point
    // output characters
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [6:0] code_char, [7] zero
    output logic        o_m_tlast   // last_char
);
    import pdce_pkg::*;

    logic              s_accept;
    logic              push;
    logic              full;
    logic              q_valid;
    logic              q_pop;
    t_entry            front_entry;
    t_entry            q_entry;
    logic [CHAR_W-1:0] code_char;

    assign o_s_tready = !full;
    assign s_accept   = i_s_tvalid && !full;

    // classify the point and form folded deltas
    pdce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_lat    (i_s_tdata[LAT_W-1:0]),
        .i_lng    (i_s_tdata[LAT_W+LNG_W-1:LAT_W]),
        .i_start  (i_s_tuser[0]),
        .i_keep   (i_s_tuser[1]),
        .o_push   (push),
        .o_entry  (front_entry)
    );

    // decouples point intake from character output
    pdce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .o_full   (full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_entry  (q_entry)
    );

    // one character per beat, latitude groups then longitude groups
    pdce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_char    (code_char),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, code_char};

endmodule
